>>> rtl/core/kaa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the k-means engine.
package kaa_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 8;
  localparam int MAX_POINTS   = 1048576;

  localparam int CL_W     = $clog2(MAX_CLUSTERS);
  localparam int DIM_W    = $clog2(MAX_DIMS);
  localparam int ADDR_W   = CL_W + DIM_W;
  localparam int NC_W     = CL_W + 1;
  localparam int ND_W     = DIM_W + 1;
  localparam int PREV_W   = 5;
  localparam int COORD_W  = 16;
  localparam int SUM_W    = 36;
  localparam int DIST_W   = 36;
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int SNAP_W   = CNT_W + 1;
  localparam int DSUM_W   = SNAP_W + CL_W;
  localparam int CFG_W    = CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    CMD_CENTROID = 3'd0,
    CMD_POINT    = 3'd1,
    CMD_READ     = 3'd2,
    CMD_CONV     = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_STATS  = 2'd1,
    KIND_CONV   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_NUM_CLUSTERS = 2'd0,
    CFG_NUM_DIMS     = 2'd1,
    CFG_TOTAL_POINTS = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN,
    ST_MV_RD,
    ST_MV_WR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CONV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              dist_issue;
    logic              dist_first;
    logic              dist_last;
    logic              mv_rd;
    logic              mv_wr;
    logic              mv_add;
    logic              cnt_en;
    logic              div_start;
    logic              conv_step;
    logic              conv_first;
    logic              out_load;
    kind_t             out_kind;
    logic [CL_W-1:0]   cl;
    logic [DIM_W-1:0]  d;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [NC_W-1:0]   nc;
    logic [ND_W-1:0]   nd;
    logic [CL_W-1:0]   best;
    logic [CL_W-1:0]   prev;
    logic              prev_valid;
    logic              changed;
    logic              div_done;
    logic              out_free;
  } dp_status_t;

endpackage

>>> rtl/core/kaa_div.sv
// Restoring divider, one quotient bit per cycle, for the cluster mean.
module kaa_div import kaa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [SUM_W-1:0]   quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       trial;
  logic                 fits;

  assign shifted  = {rem, quo[SUM_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step + DIV_CNT_W'(1);
        if (step == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/kaa_datapath.sv
// Datapath: tables, distance pipeline, accumulators, convergence sum and result register.
module kaa_datapath import kaa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 ctl,
  output dp_status_t                st,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic [2:0]                cmd,
  input  logic [CL_W-1:0]           cluster_sel,
  input  logic [DIM_W-1:0]          dim_sel,
  input  logic signed [COORD_W-1:0] coord_value,
  input  logic [PREV_W-1:0]         prev_cluster,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [1:0]                result_kind,
  output logic [CL_W-1:0]           assigned_cluster,
  output logic                      changed,
  output logic [DIST_W-1:0]         min_distance,
  output logic signed [SUM_W-1:0]   coord_sum,
  output logic [CNT_W-1:0]          member_count,
  output logic signed [COORD_W-1:0] mean_value,
  output logic                      keep_going
);

  localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int SQ_W  = 2 * (COORD_W + 1);
  localparam int ACC_W = SQ_W + DIM_W;
  localparam int KG_W  = DSUM_W + 5;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic signed [SUM_W:0] MEAN_HI = (SUM_W+1)'(2**(COORD_W-1) - 1);
  localparam logic signed [SUM_W:0] MEAN_LO = ~MEAN_HI;

  function automatic logic [COORD_W-1:0] sat16(input logic signed [SUM_W:0] v);
    logic [COORD_W-1:0] r;
    if (v > MEAN_HI) r = MEAN_HI[COORD_W-1:0];
    else if (v < MEAN_LO) r = MEAN_LO[COORD_W-1:0];
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  logic [4:0]        num_clusters;
  logic [3:0]        num_dims;
  logic [CNT_W-1:0]  total_points;
  logic [NC_W-1:0]   nc_eff;
  logic [ND_W-1:0]   nd_eff;

  logic acc_centroid, acc_point, acc_read, acc_clear;

  logic [COORD_W-1:0] cent_mem [DEPTH];
  logic [COORD_W-1:0] pt_buf [MAX_DIMS];
  logic signed [COORD_W-1:0] cent_q, pt_q;
  logic [PREV_W-1:0]  prev_l;

  logic              s1_v, s2_v;
  logic [CL_W-1:0]   s1_c, s2_c;
  logic              s1_first, s1_last, s2_first, s2_last;
  logic signed [COORD_W:0] diff;
  logic signed [SQ_W-1:0]  sq_full;
  logic [SQ_W-1:0]   sq_q;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [DIST_W-1:0] dist_sat, best_d;
  logic [CL_W-1:0]   best_c;
  logic              prev_valid, chg;

  logic [SUM_W-1:0]  sum_mem [DEPTH];
  logic [DEPTH-1:0]  sum_vld;
  logic [ADDR_W-1:0] sum_raddr;
  logic [SUM_W-1:0]  sum_q, sum_base, pt_ext, sum_new, sum_mag;
  logic              sum_vq, s_neg;

  logic [CNT_W-1:0]  cnt [MAX_CLUSTERS];
  logic [SNAP_W-1:0] snap [MAX_CLUSTERS];
  logic [CL_W-1:0]   cnt_addr;
  logic [CNT_W-1:0]  cnt_rd, cnt_q;
  logic [SNAP_W-1:0] snap_rd;
  logic signed [SNAP_W:0] cdiff;
  logic [SNAP_W:0]   cabs;
  logic              conv_use;
  logic [DSUM_W-1:0] dsum;
  logic [KG_W-1:0]   dsum20;

  logic              div_done;
  logic [SUM_W-1:0]  quo;
  logic signed [SUM_W:0] qval;
  logic [COORD_W-1:0] mean_w;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= 5'd2;
      num_dims     <= 4'd2;
      total_points <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_CLUSTERS: num_clusters <= cfg_data[4:0];
        CFG_NUM_DIMS:     num_dims     <= cfg_data[3:0];
        CFG_TOTAL_POINTS: total_points <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_clusters == 5'd0) nc_eff = NC_W'(1);
    else if (NC_W'(num_clusters) > NC_W'(MAX_CLUSTERS)) nc_eff = NC_W'(MAX_CLUSTERS);
    else nc_eff = NC_W'(num_clusters);
    if (num_dims == 4'd0) nd_eff = ND_W'(1);
    else if (ND_W'(num_dims) > ND_W'(MAX_DIMS)) nd_eff = ND_W'(MAX_DIMS);
    else nd_eff = ND_W'(num_dims);
  end

  assign acc_centroid = ctl.accept && (cmd == CMD_CENTROID);
  assign acc_point    = ctl.accept && (cmd == CMD_POINT);
  assign acc_read     = ctl.accept && (cmd == CMD_READ);
  assign acc_clear    = ctl.accept && (cmd == CMD_CLEAR);

  // Centroid table and point buffer.
  always_ff @(posedge clk) begin
    if (acc_centroid) cent_mem[{cluster_sel, dim_sel}] <= coord_value;
    if (ctl.dist_issue) cent_q <= cent_mem[{ctl.cl, ctl.d}];
  end

  always_ff @(posedge clk) begin
    if (acc_point) begin
      pt_buf[dim_sel] <= coord_value;
      prev_l          <= prev_cluster;
    end
    if (ctl.dist_issue || ctl.mv_rd) pt_q <= pt_buf[ctl.d];
  end

  // Distance pipeline: difference and square, then accumulate and compare.
  assign diff    = {cent_q[COORD_W-1], cent_q} - {pt_q[COORD_W-1], pt_q};
  assign sq_full = diff * diff;
  assign acc_next = (s2_first ? '0 : acc) + ACC_W'(sq_q);
  assign dist_sat = (acc_next > ACC_W'(DIST_MAX)) ? DIST_MAX : acc_next[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= ctl.dist_issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_c     <= ctl.cl;
    s1_first <= ctl.dist_first;
    s1_last  <= ctl.dist_last;
    s2_c     <= s1_c;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    sq_q     <= sq_full;
    if (s2_v) begin
      acc <= acc_next;
      if (s2_last && ((s2_c == '0) || (dist_sat < best_d))) begin
        best_d <= dist_sat;
        best_c <= s2_c;
      end
    end
  end

  assign prev_valid = prev_l < PREV_W'(MAX_CLUSTERS);
  assign chg        = !prev_valid || (prev_l[CL_W-1:0] != best_c);

  // Coordinate sums with per-entry valid bits standing for the cleared state.
  assign sum_raddr = acc_read ? {cluster_sel, dim_sel} : {ctl.cl, ctl.d};
  assign sum_base  = sum_vq ? sum_q : '0;
  assign pt_ext    = {{(SUM_W-COORD_W){pt_q[COORD_W-1]}}, pt_q};
  assign sum_new   = ctl.mv_add ? sum_base + pt_ext : sum_base - pt_ext;

  always_ff @(posedge clk) begin
    if (acc_read || ctl.mv_rd) begin
      sum_q  <= sum_mem[sum_raddr];
      sum_vq <= sum_vld[sum_raddr];
    end
    if (ctl.mv_wr) sum_mem[{ctl.cl, ctl.d}] <= sum_new;
  end

  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      sum_vld <= '0;
    end else if (ctl.mv_wr) begin
      sum_vld[{ctl.cl, ctl.d}] <= 1'b1;
    end
  end

  // Member counts and count snapshot.
  assign cnt_addr = acc_read ? cluster_sel : ctl.cl;
  assign cnt_rd   = cnt[cnt_addr];
  assign snap_rd  = snap[ctl.cl];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt[i]  <= '0;
        snap[i] <= '1;
      end
    end else begin
      if (acc_clear) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) cnt[i] <= '0;
      end else if (ctl.mv_wr && ctl.cnt_en) begin
        cnt[ctl.cl] <= ctl.mv_add ? cnt_rd + CNT_W'(1) : cnt_rd - CNT_W'(1);
      end
      if (ctl.conv_step) snap[ctl.cl] <= {1'b0, cnt_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (acc_read) cnt_q <= cnt_rd;
  end

  // Convergence sum of count changes over the active clusters.
  assign cdiff    = $signed({snap_rd[SNAP_W-1], snap_rd}) - $signed({2'b00, cnt_rd});
  assign cabs     = cdiff[SNAP_W] ? $unsigned(-cdiff) : $unsigned(cdiff);
  assign conv_use = {1'b0, ctl.cl} < nc_eff;
  assign dsum20   = {1'b0, dsum, 4'b0000} + {3'b000, dsum, 2'b00};

  always_ff @(posedge clk) begin
    if (ctl.conv_step) begin
      dsum <= (ctl.conv_first ? '0 : dsum) + (conv_use ? DSUM_W'(cabs) : '0);
    end
  end

  // Mean: magnitude division, then sign and saturation.
  assign s_neg   = sum_base[SUM_W-1];
  assign sum_mag = s_neg ? (~sum_base + SUM_W'(1)) : sum_base;

  kaa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (sum_mag),
    .divisor  (cnt_q),
    .done     (div_done),
    .quotient (quo)
  );

  assign qval   = s_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign mean_w = (cnt_q == '0) ? sat16($signed({sum_base[SUM_W-1], sum_base})) : sat16(qval);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result_kind      <= ctl.out_kind;
      assigned_cluster <= '0;
      changed          <= 1'b0;
      min_distance     <= '0;
      coord_sum        <= '0;
      member_count     <= '0;
      mean_value       <= '0;
      keep_going       <= 1'b0;
      case (ctl.out_kind)
        KIND_ASSIGN: begin
          assigned_cluster <= best_c;
          changed          <= chg;
          min_distance     <= best_d;
        end
        KIND_STATS: begin
          coord_sum    <= sum_base;
          member_count <= cnt_q;
          mean_value   <= mean_w;
        end
        KIND_CONV: begin
          keep_going <= dsum20 >= KG_W'(total_points);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st.nc         = nc_eff;
    st.nd         = nd_eff;
    st.best       = best_c;
    st.prev       = prev_l[CL_W-1:0];
    st.prev_valid = prev_valid;
    st.changed    = chg;
    st.div_done   = div_done;
    st.out_free   = !out_valid || !out_stall;
  end

endmodule

>>> rtl/core/kaa_ctrl.sv
// Controller state machine that sequences distance, accumulator, read and convergence work.
module kaa_ctrl import kaa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] cmd,
  input  logic       last_coord,
  output logic       in_stall,
  output ctrl_cmd_t  ctl,
  input  dp_status_t st
);

  state_t           state, state_next;
  logic [CL_W-1:0]  c_cnt, c_cnt_next;
  logic [DIM_W-1:0] d_cnt, d_cnt_next;
  logic             add_phase, add_phase_next;
  logic [1:0]       drain, drain_next;
  kind_t            kind, kind_next;
  logic             d_last, c_last, accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      c_cnt     <= '0;
      d_cnt     <= '0;
      add_phase <= 1'b0;
      drain     <= '0;
      kind      <= KIND_ASSIGN;
    end else begin
      state     <= state_next;
      c_cnt     <= c_cnt_next;
      d_cnt     <= d_cnt_next;
      add_phase <= add_phase_next;
      drain     <= drain_next;
      kind      <= kind_next;
    end
  end

  assign d_last = ({1'b0, d_cnt} + ND_W'(1)) == st.nd;
  assign c_last = ({1'b0, c_cnt} + NC_W'(1)) == st.nc;

  always_comb begin
    state_next     = state;
    c_cnt_next     = c_cnt;
    d_cnt_next     = d_cnt;
    add_phase_next = add_phase;
    drain_next     = drain;
    kind_next      = kind;
    in_stall       = (state != ST_IDLE);
    accept         = in_valid && (state == ST_IDLE);

    ctl            = '0;
    ctl.accept     = accept;
    ctl.out_kind   = kind;
    ctl.cl         = c_cnt;
    ctl.d          = d_cnt;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          c_cnt_next = '0;
          d_cnt_next = '0;
          case (cmd)
            CMD_POINT: begin
              if (last_coord) begin
                state_next = ST_DIST;
                kind_next  = KIND_ASSIGN;
              end
            end
            CMD_READ: begin
              state_next = ST_DIV_GO;
              kind_next  = KIND_STATS;
            end
            CMD_CONV: begin
              state_next = ST_CONV;
              kind_next  = KIND_CONV;
            end
            default: ;
          endcase
        end
      end
      ST_DIST: begin
        ctl.dist_issue = 1'b1;
        ctl.dist_first = (d_cnt == '0);
        ctl.dist_last  = d_last;
        if (d_last) begin
          d_cnt_next = '0;
          if (c_last) begin
            state_next = ST_DRAIN;
            drain_next = '0;
          end else begin
            c_cnt_next = c_cnt + CL_W'(1);
          end
        end else begin
          d_cnt_next = d_cnt + DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain == 2'd2) begin
          d_cnt_next = '0;
          if (st.changed) begin
            add_phase_next = !st.prev_valid;
            state_next     = ST_MV_RD;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          drain_next = drain + 2'd1;
        end
      end
      ST_MV_RD: begin
        ctl.mv_rd  = 1'b1;
        ctl.cl     = add_phase ? st.best : st.prev;
        ctl.mv_add = add_phase;
        state_next = ST_MV_WR;
      end
      ST_MV_WR: begin
        ctl.mv_wr  = 1'b1;
        ctl.cl     = add_phase ? st.best : st.prev;
        ctl.mv_add = add_phase;
        ctl.cnt_en = (d_cnt == '0);
        if (d_last) begin
          d_cnt_next = '0;
          if (add_phase) begin
            state_next = ST_DONE;
          end else begin
            add_phase_next = 1'b1;
            state_next     = ST_MV_RD;
          end
        end else begin
          d_cnt_next = d_cnt + DIM_W'(1);
          state_next = ST_MV_RD;
        end
      end
      ST_DIV_GO: begin
        ctl.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (st.div_done) state_next = ST_DONE;
      end
      ST_CONV: begin
        ctl.conv_step  = 1'b1;
        ctl.conv_first = (c_cnt == '0);
        if (c_cnt == CL_W'(MAX_CLUSTERS - 1)) begin
          state_next = ST_DONE;
        end else begin
          c_cnt_next = c_cnt + CL_W'(1);
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/kmeans_assign_accumulate.sv
// Top level of the k-means assignment and accumulation engine.
//
//   channel  signals                          item accepted when
//   in       in_valid / in_stall + 6 fields   in_valid && !in_stall
//   out      out_valid / out_stall + 8 fields out_valid && !out_stall
//   cfg      cfg_we, cfg_index, cfg_data      cfg_we
//
// Centroid writes, plain point coordinates and clears are taken without leaving the idle state.
// A last coordinate runs the distance pipeline over every active cluster and dimension,
// then a read-modify-write of the nd coordinate sums of each touched cluster (up to two).
// A cluster read waits for the one-bit-per-cycle divider to finish.
// A convergence check steps through every entry of the count table, then loads the
// result.
// Reset is synchronous; a new item is accepted while a result waits under stall.
module kmeans_assign_accumulate import kaa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                cmd,
  input  logic [CL_W-1:0]           cluster_sel,
  input  logic [DIM_W-1:0]          dim_sel,
  input  logic signed [COORD_W-1:0] coord_value,
  input  logic [PREV_W-1:0]         prev_cluster,
  input  logic                      last_coord,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                result_kind,
  output logic [CL_W-1:0]           assigned_cluster,
  output logic                      changed,
  output logic [DIST_W-1:0]         min_distance,
  output logic signed [SUM_W-1:0]   coord_sum,
  output logic [CNT_W-1:0]          member_count,
  output logic signed [COORD_W-1:0] mean_value,
  output logic                      keep_going
);

  ctrl_cmd_t  ctl;
  dp_status_t st;

  kaa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .cmd        (cmd),
    .last_coord (last_coord),
    .in_stall   (in_stall),
    .ctl        (ctl),
    .st         (st)
  );

  kaa_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .cluster_sel      (cluster_sel),
    .dim_sel          (dim_sel),
    .coord_value      (coord_value),
    .prev_cluster     (prev_cluster),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .result_kind      (result_kind),
    .assigned_cluster (assigned_cluster),
    .changed          (changed),
    .min_distance     (min_distance),
    .coord_sum        (coord_sum),
    .member_count     (member_count),
    .mean_value       (mean_value),
    .keep_going       (keep_going)
  );

endmodule

>>> rtl/core/kaa_checker.sv
// Port-level checker for the k-means engine and its bind to the top level.
module kaa_checker import kaa_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                result_kind,
  input logic [CL_W-1:0]           assigned_cluster,
  input logic                      changed,
  input logic [DIST_W-1:0]         min_distance,
  input logic signed [SUM_W-1:0]   coord_sum,
  input logic [CNT_W-1:0]          member_count,
  input logic signed [COORD_W-1:0] mean_value,
  input logic                      keep_going
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result_kind) && $stable(min_distance)
      && $stable(coord_sum) && $stable(keep_going))
    else $error("stalled result item changed");

  a_assign_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != KIND_ASSIGN) |->
      (assigned_cluster == '0) && !changed && (min_distance == '0))
    else $error("assignment fields set in a non-assignment result");

  a_stats_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != KIND_STATS) |->
      (coord_sum == '0) && (member_count == '0) && (mean_value == '0))
    else $error("statistics fields set in a non-statistics result");

endmodule

bind kmeans_assign_accumulate kaa_checker u_kaa_checker (.*);

>>> bench/kmeans_assign_accumulate_tb.sv
// Self-checking testbench for the k-means assignment and accumulation engine.
`timescale 1ns / 100ps

module kmeans_assign_accumulate_tb import kaa_pkg::*; ();

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [4:0] NO_PREV = 5'd16;
  localparam longint DIST_MAX = 64'h0000_000F_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] cl;
    logic ch;
    logic [35:0] min_d;
    logic [35:0] sum;
    logic [20:0] cnt;
    logic [15:0] mean;
    logic keep;
  } res_t;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] cs;
    logic [2:0] ds;
    logic [15:0] val;
    logic [4:0] pv;
    logic lst;
    logic lit;
    res_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = '0;
  logic [CL_W-1:0] cluster_sel = '0;
  logic [DIM_W-1:0] dim_sel = '0;
  logic signed [COORD_W-1:0] coord_value = '0;
  logic [PREV_W-1:0] prev_cluster = '0;
  logic last_coord = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [CL_W-1:0] assigned_cluster;
  logic changed;
  logic [DIST_W-1:0] min_distance;
  logic signed [SUM_W-1:0] coord_sum;
  logic [CNT_W-1:0] member_count;
  logic signed [COORD_W-1:0] mean_value;
  logic keep_going;

  kmeans_assign_accumulate uut (.*);

  always #5 clk = ~clk;

  logic signed [15:0] centroids [16][8];
  logic signed [15:0] point_buf [8];
  logic [35:0] sums [16][8];
  logic [20:0] counts [16];
  longint snapshot [16];
  logic [4:0] nc_reg;
  logic [3:0] nd_reg;
  logic [20:0] total_reg;

  res_t pending_results[$];
  row_t directed[$];
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cycles = 0;
  bit calm = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  int hold_left = 0;

  function automatic int active_clusters();
    if (nc_reg == 0) return 1;
    if (nc_reg > 16) return 16;
    return nc_reg;
  endfunction

  function automatic int active_dims();
    if (nd_reg == 0) return 1;
    if (nd_reg > 8) return 8;
    return nd_reg;
  endfunction

  task automatic move_member(input int k, input int nd, input bit add);
    logic [35:0] x;
    for (int d = 0; d < nd; d++) begin
      x = {{20{point_buf[d][15]}}, point_buf[d]};
      sums[k][d] = add ? sums[k][d] + x : sums[k][d] - x;
    end
    counts[k] = add ? counts[k] + 21'd1 : counts[k] - 21'd1;
  endtask

  task automatic predict_engine(input logic [2:0] op, input logic [3:0] cs,
                                input logic [2:0] ds, input logic signed [15:0] v,
                                input logic [4:0] pv, input logic lst,
                                output bit has, output res_t r);
    int nc, nd, best;
    longint acc, diff, bestd, s, m, dsum, dd;
    logic signed [35:0] raw;
    r = '0;
    has = 0;
    nc = active_clusters();
    nd = active_dims();
    case (op)
      CMD_CENTROID: centroids[cs][ds] = v;
      CMD_POINT: begin
        point_buf[ds] = v;
        if (lst) begin
          best = 0;
          bestd = 0;
          for (int k = 0; k < nc; k++) begin
            acc = 0;
            for (int d = 0; d < nd; d++) begin
              diff = longint'(centroids[k][d]) - longint'(point_buf[d]);
              acc += diff * diff;
            end
            if (acc > DIST_MAX) acc = DIST_MAX;
            if (k == 0 || acc < bestd) begin
              bestd = acc;
              best = k;
            end
          end
          if (pv >= 16) begin
            move_member(best, nd, 1);
          end else if (pv != best) begin
            move_member(pv, nd, 0);
            move_member(best, nd, 1);
          end
          r.kind = KIND_ASSIGN;
          r.cl = best;
          r.ch = (pv >= 16 || pv != best);
          r.min_d = bestd;
          has = 1;
        end
      end
      CMD_READ: begin
        raw = sums[cs][ds];
        s = raw;
        m = (counts[cs] == 0) ? s : s / longint'(counts[cs]);
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        r.kind = KIND_STATS;
        r.sum = raw;
        r.cnt = counts[cs];
        r.mean = m[15:0];
        has = 1;
      end
      CMD_CONV: begin
        dsum = 0;
        for (int k = 0; k < nc; k++) begin
          dd = snapshot[k] - longint'(counts[k]);
          dsum += (dd < 0) ? -dd : dd;
        end
        for (int k = 0; k < 16; k++) snapshot[k] = counts[k];
        r.kind = KIND_CONV;
        r.keep = (dsum * 20 >= longint'(total_reg));
        has = 1;
      end
      CMD_CLEAR: begin
        for (int k = 0; k < 16; k++) begin
          counts[k] = '0;
          for (int d = 0; d < 8; d++) sums[k][d] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Drives one item and holds it until the block takes it.
  task automatic send_item(input logic [2:0] op, input logic [3:0] cs, input logic [2:0] ds,
                           input logic [15:0] v, input logic [4:0] pv, input logic lst,
                           input bit lit = 0, input res_t lit_r = '0);
    bit has;
    res_t r;
    cmd <= op;
    cluster_sel <= cs;
    dim_sel <= ds;
    coord_value <= v;
    prev_cluster <= pv;
    last_coord <= lst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_engine(op, cs, ds, v, pv, lst, has, r);
    if (has) pending_results.push_back(lit ? lit_r : r);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NUM_CLUSTERS: nc_reg = value;
      CFG_NUM_DIMS: nd_reg = value;
      default: total_reg = value;
    endcase
  endtask

  task automatic random_item();
    int pick, nd, c;
    logic [15:0] v;
    logic [4:0] pv;
    pick = $urandom_range(0, 99);
    nd = active_dims();
    if (pick < 62) begin
      c = $urandom_range(0, active_clusters() - 1);
      pv = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 15) : $urandom_range(16, 31);
      for (int d = 0; d < nd; d++) begin
        if ($urandom_range(0, 3) == 0) v = $urandom;
        else v = centroids[c][d] + $urandom_range(0, 1023) - 512;
        send_item(CMD_POINT, $urandom, d, v, pv, d == nd - 1);
      end
    end else if (pick < 74) begin
      send_item(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 82) begin
      send_item(CMD_CONV, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 84) begin
      send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 91) begin
      send_item(CMD_CENTROID, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 95) begin
      send_item(CMD_POINT, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_item($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI), $urandom, $urandom, $urandom,
                $urandom, $urandom);
    end
  endtask

  function automatic row_t mk(logic [2:0] op, logic [3:0] cs, logic [2:0] ds,
                              logic [15:0] v, logic [4:0] pv, logic lst,
                              logic lit = 0, res_t r = '0);
    return '{op, cs, ds, v, pv, lst, lit, r};
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= 600;
      hold_taken <= 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("Result with no item outstanding: kind %0d", result_kind);
        errors++;
      end else begin
        e = pending_results.pop_front();
        results_checked++;
        if (result_kind !== e.kind) begin
          $error("result_kind expected %0d got %0d", e.kind, result_kind); errors++;
        end
        if (assigned_cluster !== e.cl) begin
          $error("assigned_cluster expected %0d got %0d", e.cl, assigned_cluster); errors++;
        end
        if (changed !== e.ch) begin
          $error("changed expected %0d got %0d", e.ch, changed); errors++;
        end
        if (min_distance !== e.min_d) begin
          $error("min_distance expected %0h got %0h", e.min_d, min_distance); errors++;
        end
        if (coord_sum !== e.sum) begin
          $error("coord_sum expected %0h got %0h", e.sum, coord_sum); errors++;
        end
        if (member_count !== e.cnt) begin
          $error("member_count expected %0d got %0d", e.cnt, member_count); errors++;
        end
        if (mean_value !== e.mean) begin
          $error("mean_value expected %0h got %0h", e.mean, mean_value); errors++;
        end
        if (keep_going !== e.keep) begin
          $error("keep_going expected %0d got %0d", e.keep, keep_going); errors++;
        end
      end
    end
  end

  initial begin
    res_t zero_stats, conv_one, tie_win;
    int phase_nc [6] = '{16, 1, 0, 31, 4, 7};
    int phase_nd [6] = '{8, 1, 0, 15, 3, 8};
    int phase_tp [6] = '{20, 0, 2097151, 100, 50, 1};
    nc_reg = 2;
    nd_reg = 2;
    total_reg = 1;
    for (int k = 0; k < 16; k++) begin
      counts[k] = '0;
      snapshot[k] = -1;
      for (int d = 0; d < 8; d++) sums[k][d] = '0;
    end
    zero_stats = '0;
    zero_stats.kind = KIND_STATS;
    conv_one = '0;
    conv_one.kind = KIND_CONV;
    conv_one.keep = 1'b1;
    tie_win = '0;
    tie_win.kind = KIND_ASSIGN;
    tie_win.ch = 1'b1;

    directed.push_back(mk(CMD_READ, 4'd3, 3'd5, 16'h7fff, NO_PREV, 1'b1, 1, zero_stats));
    directed.push_back(mk(CMD_CONV, 4'd0, 3'd0, 16'h0, 5'd0, 1'b0, 1, conv_one));
    directed.push_back(mk(CMD_SPARE_LO, 4'd15, 3'd7, 16'hffff, 5'd31, 1'b1));
    directed.push_back(mk(CMD_SPARE_HI, 4'd0, 3'd0, 16'h0, 5'd0, 1'b0));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd0, 16'h7fff, NO_PREV, 1'b0));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd1, 16'h8000, NO_PREV, 1'b1));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd0, 16'h8000, 5'd0, 1'b0));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd1, 16'h7fff, 5'd0, 1'b1));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd0, 16'h0000, 5'd31, 1'b0));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd1, 16'h0000, 5'd1, 1'b1));
    directed.push_back(mk(CMD_READ, 4'd0, 3'd0, 16'h0, 5'd0, 1'b0));
    directed.push_back(mk(CMD_READ, 4'd1, 3'd1, 16'h0, 5'd0, 1'b0));
    directed.push_back(mk(CMD_READ, 4'd15, 3'd7, 16'h0, 5'd0, 1'b0));
    directed.push_back(mk(CMD_CONV, 4'd0, 3'd0, 16'h0, 5'd0, 1'b0));
    directed.push_back(mk(CMD_CENTROID, 4'd0, 3'd0, 16'h0100, 5'd0, 1'b0));
    directed.push_back(mk(CMD_CENTROID, 4'd0, 3'd1, 16'h0100, 5'd0, 1'b0));
    directed.push_back(mk(CMD_CENTROID, 4'd1, 3'd0, 16'h0100, 5'd0, 1'b0));
    directed.push_back(mk(CMD_CENTROID, 4'd1, 3'd1, 16'h0100, 5'd0, 1'b0));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd0, 16'h0100, 5'd1, 1'b0));
    directed.push_back(mk(CMD_POINT, 4'd0, 3'd1, 16'h0100, 5'd1, 1'b1, 1, tie_win));
    directed.push_back(mk(CMD_CLEAR, 4'd0, 3'd0, 16'h0, 5'd0, 1'b0));
    directed.push_back(mk(CMD_READ, 4'd1, 3'd0, 16'h0, 5'd0, 1'b0, 1, zero_stats));
    directed.push_back(mk(CMD_CONV, 4'd0, 3'd0, 16'h0, 5'd0, 1'b0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(directed[0].op, directed[0].cs, directed[0].ds, directed[0].val,
              directed[0].pv, directed[0].lst, 1, directed[0].r);
    send_item(directed[1].op, directed[1].cs, directed[1].ds, directed[1].val,
              directed[1].pv, directed[1].lst, 1, directed[1].r);
    for (int k = 0; k < 16; k++)
      for (int d = 0; d < 8; d++)
        send_item(CMD_CENTROID, k, d, $urandom, $urandom, $urandom);
    for (int d = 0; d < 8; d++)
      send_item(CMD_POINT, $urandom, d, $urandom, $urandom, 1'b0);
    for (int i = 2; i < directed.size(); i++)
      send_item(directed[i].op, directed[i].cs, directed[i].ds, directed[i].val,
                directed[i].pv, directed[i].lst, directed[i].lit, directed[i].r);

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_NUM_CLUSTERS, phase_nc[p]);
      write_reg(CFG_NUM_DIMS, phase_nd[p]);
      write_reg(CFG_TOTAL_POINTS, phase_tp[p]);
      calm = (p == 1);
      if (p == 3) hold_req = 1;
      for (int i = 0; i < 25; i++) random_item();
    end
    calm = 0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items over six register settings; checked %0d results.",
             items_sent, results_checked);
    $display("Covered assignment ties, moves, reads, convergence checks and clears.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/kaa_pkg.sv
rtl/core/kaa_div.sv
rtl/core/kaa_datapath.sv
rtl/core/kaa_ctrl.sv
rtl/core/kmeans_assign_accumulate.sv
rtl/core/kaa_checker.sv
bench/kmeans_assign_accumulate_tb.sv
